// ===== sv/lgrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgrs_pkg
// Shared constants, types and the B3/S23 cell rule for the row stream unit.
// ----------------------------------------------------------------------------
package lgrs_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int CFG_W       = 7;
    localparam int QUEUE_DEPTH = 3;
    localparam int QCNT_W      = 2;

    localparam logic [CFG_W-1:0] GRID_WIDTH_RESET = CFG_W'(40);

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // One column's cell bits as seen by the neighbor cells.
    typedef struct packed {
        logic upper;
        logic middle;
        logic current;
    } col_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

    typedef struct packed {
        logic [MAX_WIDTH-1:0] cells;
        logic                 frame_end;
    } res_t;

    function automatic logic [3:0] count8(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + {3'b000, b[i]};
        end
        return n;
    endfunction

    function automatic logic life_next(input logic [3:0] n, input logic alive);
        return (n == BIRTH_COUNT) || ((n == SURVIVE_COUNT) && alive);
    endfunction

endpackage

// ===== sv/lgrs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgrs_if
// Valid/ready channels: input rows, result rows and the width register.
// ----------------------------------------------------------------------------
interface lgrs_row_if import lgrs_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [MAX_WIDTH-1:0] row_cells;
    logic                 last_row;

    modport source (output valid, output row_cells, output last_row, input ready);
    modport sink   (input valid, input row_cells, input last_row, output ready);
endinterface

interface lgrs_res_if import lgrs_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [MAX_WIDTH-1:0] next_cells;
    logic                 frame_end;

    modport source (output valid, output next_cells, output frame_end, input ready);
    modport sink   (input valid, input next_cells, input frame_end, output ready);
endinterface

interface lgrs_cfg_if import lgrs_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] grid_width;

    modport source (output valid, output grid_width, input ready);
    modport sink   (input valid, input grid_width, output ready);
endinterface

// ===== sv/life_generation_row_stream_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_generation_row_stream_unit
// One generation of Life (B3/S23) over a grid streamed one row per item.
// ----------------------------------------------------------------------------
// Channels: rows (row_cells, last_row) in, results (next_cells, frame_end)
// out, cfg carries grid_width (columns at or beyond it are dead; values
// above 64 act as 64). cfg is always ready; write it only between frames
// or while no item is in flight.
// A row of 64 column cells holds the two previous rows; each cell trades its
// bits with its neighbors and evaluates its column in the same cycle.
// Row r of the next generation is queued when row r+1 is accepted; the item
// with last_row queues two rows (the one before and the last, frame_end=1),
// or only the last when it is also the first, and clears the cells for the
// next frame. A first row that is not the last gives no result.
// Throughput: one item per cycle while rows.ready is high.
// A three-entry result queue decouples the sides: rows.ready drops only
// while two or more results wait, so a stalled receiver backs up the input
// after at most two queued results. Reset empties the queue, clears the
// held rows and sets grid_width to 40.
// ----------------------------------------------------------------------------
module life_generation_row_stream_unit import lgrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lgrs_row_if.sink   rows,
    lgrs_res_if.source results,
    lgrs_cfg_if.sink   cfg
);

    logic [CFG_W-1:0]     grid_width_reg;
    logic [CFG_W-1:0]     grid_width_next;
    logic                 primed_reg;
    logic                 primed_next;
    logic                 accept;
    logic                 space;
    cell_ctl_t            ctl;
    logic [MAX_WIDTH-1:0] in_use;
    logic [MAX_WIDTH-1:0] res_mid;
    logic [MAX_WIDTH-1:0] res_last;
    col_t                 col [MAX_WIDTH];
    logic [QCNT_W-1:0]    push_cnt;
    res_t                 push0;
    res_t                 push1;

    assign cfg.ready  = 1'b1;
    assign rows.ready = space;
    assign accept     = rows.valid && space;
    assign ctl.shift  = accept;
    assign ctl.clear  = rows.last_row;

    always_comb
    begin
        for (int c = 0; c < MAX_WIDTH; c++)
        begin
            in_use[c] = (grid_width_reg > CFG_W'(c));
        end
    end

    genvar gc;
    generate
        for (gc = 0; gc < MAX_WIDTH; gc++)
        begin : g_col
            col_t nb_left;
            col_t nb_right;
            if (gc == 0)
            begin : g_lo
                assign nb_left = '0;
            end
            else
            begin : g_li
                assign nb_left = col[gc-1];
            end
            if (gc == MAX_WIDTH - 1)
            begin : g_ro
                assign nb_right = '0;
            end
            else
            begin : g_ri
                assign nb_right = col[gc+1];
            end
            lgrs_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .in_use   (in_use[gc]),
                .cur_bit  (rows.row_cells[gc]),
                .left     (nb_left),
                .right    (nb_right),
                .own      (col[gc]),
                .res_mid  (res_mid[gc]),
                .res_last (res_last[gc])
            );
        end
    endgenerate

    always_comb
    begin
        push_cnt = '0;
        if (accept)
            push_cnt = {{(QCNT_W-1){1'b0}}, primed_reg}
                     + {{(QCNT_W-1){1'b0}}, rows.last_row};
        push1.cells     = res_last;
        push1.frame_end = 1'b1;
        if (primed_reg)
        begin
            push0.cells     = res_mid;
            push0.frame_end = 1'b0;
        end
        else
        begin
            push0 = push1;
        end
    end

    lgrs_out_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .push0    (push0),
        .push1    (push1),
        .space    (space),
        .results  (results)
    );

    always_comb
    begin
        grid_width_next = grid_width_reg;
        primed_next     = primed_reg;
        if (cfg.valid)
            grid_width_next = cfg.grid_width;
        if (accept)
            primed_next = !rows.last_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= GRID_WIDTH_RESET;
            primed_reg     <= 1'b0;
        end
        else
        begin
            grid_width_reg <= grid_width_next;
            primed_reg     <= primed_next;
        end
    end

endmodule

// ===== sv/lgrs_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgrs_cell
// One grid column: holds the two previous rows' bits and evaluates the
// B3/S23 rule for the middle row and for the arriving row.
// ----------------------------------------------------------------------------
module lgrs_cell import lgrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  logic      in_use,
    input  logic      cur_bit,
    input  col_t      left,
    input  col_t      right,
    output col_t      own,
    output logic      res_mid,
    output logic      res_last
);

    logic upper_reg;
    logic upper_next;
    logic middle_reg;
    logic middle_next;
    logic [3:0] n_mid;
    logic [3:0] n_last;

    assign own.upper   = upper_reg & in_use;
    assign own.middle  = middle_reg & in_use;
    assign own.current = cur_bit & in_use;

    always_comb
    begin
        n_mid  = count8({left.upper, own.upper, right.upper,
                         left.middle, right.middle,
                         left.current, own.current, right.current});
        n_last = count8({left.middle, own.middle, right.middle,
                         left.current, right.current, 3'b000});
        res_mid  = in_use & life_next(n_mid, own.middle);
        res_last = in_use & life_next(n_last, own.current);
    end

    always_comb
    begin
        upper_next  = upper_reg;
        middle_next = middle_reg;
        if (ctl.shift)
        begin
            if (ctl.clear)
            begin
                upper_next  = 1'b0;
                middle_next = 1'b0;
            end
            else
            begin
                upper_next  = middle_reg;
                middle_next = own.current;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg  <= 1'b0;
            middle_reg <= 1'b0;
        end
        else
        begin
            upper_reg  <= upper_next;
            middle_reg <= middle_next;
        end
    end

endmodule

// ===== sv/lgrs_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgrs_out_queue
// Three-entry result queue; takes up to two rows per cycle, head registered.
// ----------------------------------------------------------------------------
module lgrs_out_queue import lgrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [QCNT_W-1:0] push_cnt,
    input  res_t              push0,
    input  res_t              push1,
    output logic              space,
    lgrs_res_if.source        results
);

    res_t              q_reg  [QUEUE_DEPTH];
    res_t              q_next [QUEUE_DEPTH];
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic [QCNT_W-1:0] cnt_after;
    logic              pop;

    assign pop                = results.valid && results.ready;
    assign results.valid      = (cnt_reg != '0);
    assign results.next_cells = q_reg[0].cells;
    assign results.frame_end  = q_reg[0].frame_end;
    assign space              = (cnt_reg <= QCNT_W'(1));

    always_comb
    begin
        cnt_after = cnt_reg - {{(QCNT_W-1){1'b0}}, pop};
        cnt_next  = cnt_after + push_cnt;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (pop && (i < QUEUE_DEPTH - 1))
                q_next[i] = q_reg[i+1];
            else
                q_next[i] = q_reg[i];
            if ((push_cnt != '0) && (QCNT_W'(i) == cnt_after))
                q_next[i] = push0;
            if ((push_cnt == QCNT_W'(2)) && (QCNT_W'(i) == cnt_after + QCNT_W'(1)))
                q_next[i] = push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

// ===== sv/lgrs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgrs_checker
// Port-level checks for the row stream unit, bound to the top level.
// ----------------------------------------------------------------------------
module lgrs_checker import lgrs_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic rows_valid,
    input logic rows_ready,
    input logic rows_last,
    input logic res_valid,
    input logic res_ready,
    input logic res_end
);

    // result stays offered while stalled
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // input backs up only behind queued results
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !rows_ready |-> res_valid)
        else $error("input stalled with no result waiting");

    // last row always produces a result next cycle
    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        rows_valid && rows_ready && rows_last |=> res_valid)
        else $error("no result after last row");

    // frame end mark holds while the result is stalled
    a_end_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_end))
        else $error("frame_end changed while stalled");

endmodule

bind life_generation_row_stream_unit lgrs_checker u_lgrs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rows_valid (rows.valid),
    .rows_ready (rows.ready),
    .rows_last  (rows.last_row),
    .res_valid  (results.valid),
    .res_ready  (results.ready),
    .res_end    (results.frame_end)
);
